// ===== hw/rtl/tfr_pkg.sv =====
// Shared types and constants for the texel format converter.
`default_nettype none

package tfr_pkg;

    // Source format codes held in the source_format register.
    typedef enum logic [2:0] {
        FMT_BGRA8 = 3'd0,
        FMT_RGBA8 = 3'd1,
        FMT_ABGR8 = 3'd2,
        FMT_ARGB8 = 3'd3,
        FMT_BGR8  = 3'd4,
        FMT_RGB8  = 3'd5,
        FMT_P8    = 3'd6,
        FMT_UNSUP = 3'd7
    } t_fmt;

    // Request codes on the req_type field.
    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    // Register index (paddr[2]) of the source_format register.
    localparam logic REG_SOURCE_FORMAT = 1'b0;

    localparam t_fmt FMT_RESET = FMT_RGBA8;

    localparam int PALETTE_DEPTH_DEF = 256;

    // One converted texel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       unsupported;
    } t_pix;

endpackage

`default_nettype wire

// ===== hw/rtl/tfr_palette_ram.sv =====
// Palette memory: one write port, one read port with registered read data.
`default_nettype none

module tfr_palette_ram #(
    parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_wr_en,
    input  wire logic [$clog2(PALETTE_DEPTH)-1:0]   i_wr_addr,
    input  wire logic [31:0]                        i_wr_data,
    input  wire logic                               i_rd_en,
    input  wire logic [$clog2(PALETTE_DEPTH)-1:0]   i_rd_addr,
    output logic      [31:0]                        o_rd_data
);

    logic [31:0] r_mem [PALETTE_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Hold read data while the consumer stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hw/rtl/tfr_swizzle.sv =====
// Byte swizzle and palette unpack from source format to RGBA8 channels.
`default_nettype none

module tfr_swizzle (
    input  wire tfr_pkg::t_fmt i_fmt,
    input  wire logic [31:0]   i_texel_bytes,
    input  wire logic [31:0]   i_pal_entry,
    input  wire logic          i_pal_oor,
    output tfr_pkg::t_pix      o_pix
);

    logic [7:0] b0, b1, b2, b3;
    logic [7:0] p0, p1, p2, p3;

    assign b0 = i_texel_bytes[7:0];
    assign b1 = i_texel_bytes[15:8];
    assign b2 = i_texel_bytes[23:16];
    assign b3 = i_texel_bytes[31:24];

    assign p0 = i_pal_entry[7:0];
    assign p1 = i_pal_entry[15:8];
    assign p2 = i_pal_entry[23:16];
    assign p3 = i_pal_entry[31:24];

    always_comb begin
        o_pix = '0;
        case (i_fmt)
            tfr_pkg::FMT_BGRA8: begin
                o_pix.red = b2; o_pix.green = b1; o_pix.blue = b0; o_pix.alpha = b3;
            end
            tfr_pkg::FMT_RGBA8: begin
                o_pix.red = b0; o_pix.green = b1; o_pix.blue = b2; o_pix.alpha = b3;
            end
            tfr_pkg::FMT_ABGR8: begin
                o_pix.red = b3; o_pix.green = b2; o_pix.blue = b1; o_pix.alpha = b0;
            end
            tfr_pkg::FMT_ARGB8: begin
                o_pix.red = b1; o_pix.green = b2; o_pix.blue = b3; o_pix.alpha = b0;
            end
            tfr_pkg::FMT_BGR8: begin
                o_pix.red = b2; o_pix.green = b1; o_pix.blue = b0;
            end
            tfr_pkg::FMT_RGB8: begin
                o_pix.red = b0; o_pix.green = b1; o_pix.blue = b2;
            end
            tfr_pkg::FMT_P8: begin
                // out-of-range index reads as zero colour
                if (!i_pal_oor) begin
                    o_pix.red = p2; o_pix.green = p1; o_pix.blue = p0; o_pix.alpha = p3;
                end
            end
            default: begin
                o_pix.unsupported = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/texel_format_to_rgba8.sv =====
// Top level of the texel format to RGBA8 converter.
`default_nettype none

// Converts one texel per item to RGBA8 according to the source_format register
// (APB address 0x0, bits 2:0; 0 BGRA8, 1 RGBA8, 2 ABGR8, 3 ARGB8, 4 BGR8,
// 5 RGB8, 6 P8, 7 unsupported; reset RGBA8). An item with req_type 1 writes
// palette_word into palette entry palette_slot and returns no result; an item
// with req_type 0 converts texel_bytes and returns exactly one result. P8
// texels look up the palette with the index in texel_bytes[7:0]; read only
// entries that were written before, since the palette memory has no reset.
// An index at or above PALETTE_DEPTH gives zero colour, and a palette write to
// such a slot is dropped. The block takes one item every clock cycle when the
// output side keeps up; each convert item passes through the input register,
// the palette read register and the output register in that order. The
// registered palette read is issued as an item leaves the input register and
// lands in the middle stage. Palette writes occupy one input slot each.
// Change source_format only while the pipeline is empty.
module texel_format_to_rgba8 #(
    parameter int PALETTE_DEPTH = tfr_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [31:0] i_texel_bytes,
    input  wire logic [7:0]  i_palette_slot,
    input  wire logic [31:0] i_palette_word,

    // Result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_unsupported
);

    localparam int IdxW = $clog2(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    tfr_pkg::t_fmt r_src_fmt;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == tfr_pkg::REG_SOURCE_FORMAT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= tfr_pkg::FMT_RESET;
        end else if (cfg_wr) begin
            r_src_fmt <= tfr_pkg::t_fmt'(pwdata[2:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tfr_pkg::REG_SOURCE_FORMAT) begin
            prdata = {29'd0, r_src_fmt};
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage advances when the next one frees up.
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid;
    logic a_free, b_free, c_free;
    logic a_go, b_go;

    assign c_free = !r_c_valid || i_out_ready;
    assign b_free = !r_b_valid || c_free;
    assign a_free = !r_a_valid || b_free;
    assign a_go   = r_a_valid && b_free;
    assign b_go   = r_b_valid && c_free;

    assign o_in_ready = a_free;

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic        r_a_req;
    logic [31:0] r_a_tex;
    logic [7:0]  r_a_slot;
    logic [31:0] r_a_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_in_valid) begin
            r_a_req  <= i_req_type;
            r_a_tex  <= i_texel_bytes;
            r_a_slot <= i_palette_slot;
            r_a_word <= i_palette_word;
        end
    end

    // ------------------------------------------------------------------
    // Palette access between stage A and stage B. Writes and reads both
    // happen as an item leaves stage A, so item order is kept.
    // ------------------------------------------------------------------
    logic            a_is_conv;
    logic            pal_wr_en;
    logic            pal_rd_en;
    logic            a_idx_oor;
    logic [31:0]     pal_rd_data;

    assign a_is_conv = (r_a_req == tfr_pkg::REQ_CONVERT);
    assign pal_wr_en = a_go && (r_a_req == tfr_pkg::REQ_PALETTE)
                       && (int'(r_a_slot) < PALETTE_DEPTH);
    assign pal_rd_en = a_go && a_is_conv;
    assign a_idx_oor = (int'(r_a_tex[7:0]) >= PALETTE_DEPTH);

    tfr_palette_ram #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (pal_wr_en),
        .i_wr_addr (r_a_slot[IdxW-1:0]),
        .i_wr_data (r_a_word),
        .i_rd_en   (pal_rd_en),
        .i_rd_addr (r_a_tex[IdxW-1:0]),
        .o_rd_data (pal_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage B: texel and palette data; palette writes drop out here.
    // ------------------------------------------------------------------
    logic [31:0] r_b_tex;
    logic        r_b_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= a_go && a_is_conv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pal_rd_en) begin
            r_b_tex <= r_a_tex;
            r_b_oor <= a_idx_oor;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: swizzle into the output register
    // ------------------------------------------------------------------
    tfr_pkg::t_pix n_c_pix;
    tfr_pkg::t_pix r_c_pix;

    tfr_swizzle u_swizzle (
        .i_fmt         (r_src_fmt),
        .i_texel_bytes (r_b_tex),
        .i_pal_entry   (pal_rd_data),
        .i_pal_oor     (r_b_oor),
        .o_pix         (n_c_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_c_pix <= n_c_pix;
        end
    end

    assign o_out_valid   = r_c_valid;
    assign o_red         = r_c_pix.red;
    assign o_green       = r_c_pix.green;
    assign o_blue        = r_c_pix.blue;
    assign o_alpha       = r_c_pix.alpha;
    assign o_unsupported = r_c_pix.unsupported;

`ifndef SYNTHESIS
    // A palette write never reaches the result side.
    a_pal_write_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_go && (r_a_req == tfr_pkg::REQ_PALETTE)) |=> !r_b_valid)
        else $error("palette write item entered stage B");

    // An unsupported result carries zero colour.
    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unsupported) |->
        (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0))
        else $error("unsupported result with nonzero channels");

    // Palette read data holds while stage B waits on the output side.
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !c_free) |=> $stable(pal_rd_data))
        else $error("palette read data changed under a stalled item");
`endif

endmodule

`default_nettype wire
